>>> rtl/dldg_pkg.sv
package dldg_pkg;

    localparam int unsigned X_W     = 10;
    localparam int unsigned Y_W     = 9;
    localparam int unsigned ERR_W   = 12;
    localparam int unsigned DIST_W  = 6;
    localparam int unsigned LEN_W   = 4;
    localparam int unsigned COUNT_W = 7;   // holds 0..64
    localparam int unsigned GUARD_W = 13;  // holds 0..4096

    localparam logic [LEN_W-1:0] RESET_RUN_LENGTH = 4'd5;

    // Register indexes on the configuration port
    localparam logic REG_DASH_LENGTH = 1'b0;
    localparam logic REG_GAP_LENGTH  = 1'b1;

    typedef struct packed {
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
    } point_t;

    typedef struct packed {
        point_t first;
        point_t final_pt;
    } dash_t;

    // Walker state handed to the step unit
    typedef struct packed {
        point_t                    pos;
        logic signed [ERR_W-1:0]   err;
        logic [X_W-1:0]            dx;
        logic [Y_W-1:0]            dy;
        logic                      step_x_up;
        logic                      step_y_up;
    } walk_t;

    // Result of one Bresenham step
    typedef struct packed {
        point_t                    pos;
        logic signed [ERR_W-1:0]   err;
    } step_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SETUP  = 4'b0010,
        ST_WALK   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

endpackage

>>> rtl/dashed_line_dash_generator_unit.sv
// Dashed line generator: walks the 8-connected Bresenham line of a request
// and returns each complete dash as a start and end pixel.
// Input channel (in_valid/in_ready) takes start_x/start_y, end_x/end_y and
// phase. Output channel (out_valid/out_ready) gives one transfer per dash;
// the final one carries last. A line with no complete dash gives a single
// transfer with dash_valid low, last high and zero coordinates. A dash still
// open at the end pixel is dropped; at most 64 dashes are returned.
// Configuration: cfg_en writes cfg_data into dash_length (index 0) or
// gap_length (index 1); both reset to 5.
// Timing: the walk takes one Bresenham step per cycle through a single step
// unit while no stalled receiver halts it. in_ready is low from the input
// transfer until the last result is loaded into the output register, so a
// new request is taken only once the previous line is finished.
// Each closed dash is held until the next closes, so a dash goes out when its
// successor closes or when the walk ends. A stalled receiver halts the walk
// only when a held dash must go out while the output register is still full.
// Reset returns to idle with the output empty and both lengths at 5.
module dashed_line_dash_generator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_en,
    input  logic        cfg_addr,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [9:0]  start_x,
    input  logic [8:0]  start_y,
    input  logic [9:0]  end_x,
    input  logic [8:0]  end_y,
    input  logic [3:0]  phase,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [9:0]  dash_start_x,
    output logic [8:0]  dash_start_y,
    output logic [9:0]  dash_end_x,
    output logic [8:0]  dash_end_y,
    output logic        dash_valid,
    output logic        last
);

    localparam int unsigned DW = dldg_pkg::DIST_W;

    dldg_pkg::state_t                   state_reg;
    logic [dldg_pkg::LEN_W-1:0]         dash_len_reg;
    logic [dldg_pkg::LEN_W-1:0]         gap_len_reg;

    dldg_pkg::point_t                   pos_reg;
    dldg_pkg::point_t                   end_reg;
    logic [dldg_pkg::X_W-1:0]           dx_reg;
    logic [dldg_pkg::Y_W-1:0]           dy_reg;
    logic                               step_x_up_reg;
    logic                               step_y_up_reg;
    logic signed [dldg_pkg::ERR_W-1:0]  err_reg;
    logic signed [DW-1:0]               dist_reg;
    logic                               in_dash_reg;
    dldg_pkg::point_t                   open_reg;
    dldg_pkg::dash_t                    held_reg;
    logic                               held_valid_reg;
    logic [dldg_pkg::COUNT_W-1:0]       count_reg;
    logic [dldg_pkg::GUARD_W-1:0]       guard_reg;

    logic                               out_valid_reg;
    dldg_pkg::dash_t                    out_dash_reg;
    logic                               out_dash_valid_reg;
    logic                               out_last_reg;

    dldg_pkg::walk_t                    walk_cur;
    dldg_pkg::step_t                    walk_nxt;

    logic                               in_xfer;
    logic                               out_free;
    logic                               at_end;
    logic                               dist_in_dash;
    logic                               open_now;
    logic                               dash_open;
    dldg_pkg::point_t                   open_pt;
    logic signed [DW:0]                 dist_inc;
    logic [dldg_pkg::LEN_W:0]           period;
    logic                               wrap;
    logic                               close;
    logic                               keep;
    logic                               emit_walk;
    logic                               advance;
    logic                               emit_final;
    logic [dldg_pkg::X_W-1:0]           dx_in;
    logic [dldg_pkg::Y_W-1:0]           dy_in;

    assign in_ready = (state_reg == dldg_pkg::ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign dx_in = (start_x < end_x) ? end_x - start_x : start_x - end_x;
    assign dy_in = (start_y < end_y) ? end_y - start_y : start_y - end_y;

    always_comb
    begin
        walk_cur.pos       = pos_reg;
        walk_cur.err       = err_reg;
        walk_cur.dx        = dx_reg;
        walk_cur.dy        = dy_reg;
        walk_cur.step_x_up = step_x_up_reg;
        walk_cur.step_y_up = step_y_up_reg;
    end

    dldg_bres_step u_step (
        .cur (walk_cur),
        .nxt (walk_nxt)
    );

    always_comb
    begin
        at_end       = (pos_reg == end_reg) || guard_reg[dldg_pkg::GUARD_W-1];
        dist_in_dash = !dist_reg[DW-1] &&
                       ({1'b0, dist_reg[DW-2:0]} <
                        {{(DW - dldg_pkg::LEN_W){1'b0}}, dash_len_reg});
        open_now     = dist_in_dash && !in_dash_reg;
        dash_open    = in_dash_reg || open_now;
        open_pt      = open_now ? pos_reg : open_reg;
        dist_inc     = {dist_reg[DW-1], dist_reg} + {{DW{1'b0}}, 1'b1};
        period       = {1'b0, dash_len_reg} + {1'b0, gap_len_reg};
        wrap         = dist_inc >= $signed({{(DW - dldg_pkg::LEN_W){1'b0}}, period});
        close        = !wrap && dash_open &&
                       (dist_inc >= $signed({{(DW + 1 - dldg_pkg::LEN_W){1'b0}},
                                             dash_len_reg}));
        // Dashes past the 64th are dropped
        keep         = close && !count_reg[dldg_pkg::COUNT_W-1];
        emit_walk    = keep && held_valid_reg;
        advance      = (state_reg == dldg_pkg::ST_WALK) && !at_end &&
                       !(emit_walk && !out_free);
        emit_final   = (state_reg == dldg_pkg::ST_FINISH) && out_free;
    end

    // Sequencer and walk control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dldg_pkg::ST_IDLE;
            dash_len_reg   <= dldg_pkg::RESET_RUN_LENGTH;
            gap_len_reg    <= dldg_pkg::RESET_RUN_LENGTH;
            dist_reg       <= '0;
            in_dash_reg    <= 1'b0;
            held_valid_reg <= 1'b0;
            count_reg      <= '0;
            guard_reg      <= '0;
        end
        else
        begin
            if (cfg_en)
            begin
                unique case (cfg_addr)
                    dldg_pkg::REG_DASH_LENGTH: dash_len_reg <= cfg_data;
                    dldg_pkg::REG_GAP_LENGTH:  gap_len_reg  <= cfg_data;
                    default: ;
                endcase
            end

            unique case (state_reg)
                dldg_pkg::ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg      <= dldg_pkg::ST_SETUP;
                        dist_reg       <= -$signed({{(DW - dldg_pkg::LEN_W){1'b0}}, phase});
                        in_dash_reg    <= 1'b0;
                        held_valid_reg <= 1'b0;
                        count_reg      <= '0;
                        guard_reg      <= '0;
                    end
                end
                dldg_pkg::ST_SETUP:
                begin
                    state_reg <= dldg_pkg::ST_WALK;
                end
                dldg_pkg::ST_WALK:
                begin
                    if (at_end)
                    begin
                        state_reg <= dldg_pkg::ST_FINISH;
                    end
                    else if (advance)
                    begin
                        dist_reg    <= wrap ? '0 : dist_inc[DW-1:0];
                        in_dash_reg <= close ? 1'b0 : dash_open;
                        guard_reg   <= guard_reg + 1'b1;
                        if (keep)
                        begin
                            held_valid_reg <= 1'b1;
                            count_reg      <= count_reg + 1'b1;
                        end
                    end
                end
                dldg_pkg::ST_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= dldg_pkg::ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= dldg_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // Walk datapath
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pos_reg       <= '{x: start_x, y: start_y};
            end_reg       <= '{x: end_x, y: end_y};
            dx_reg        <= dx_in;
            dy_reg        <= dy_in;
            step_x_up_reg <= start_x < end_x;
            step_y_up_reg <= start_y < end_y;
        end
        else if (state_reg == dldg_pkg::ST_SETUP)
        begin
            err_reg <= $signed({{(dldg_pkg::ERR_W - dldg_pkg::X_W){1'b0}}, dx_reg}) -
                       $signed({{(dldg_pkg::ERR_W - dldg_pkg::Y_W){1'b0}}, dy_reg});
        end
        else if (advance)
        begin
            pos_reg  <= walk_nxt.pos;
            err_reg  <= walk_nxt.err;
            open_reg <= open_pt;
            if (keep)
            begin
                held_reg <= '{first: open_pt, final_pt: pos_reg};
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((advance && emit_walk) || emit_final)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit_walk)
        begin
            out_dash_reg       <= held_reg;
            out_dash_valid_reg <= 1'b1;
            out_last_reg       <= 1'b0;
        end
        else if (emit_final)
        begin
            // Final transfer: the held dash, or for an empty line zero coordinates with dash_valid low
            out_dash_reg       <= held_valid_reg ? held_reg : '0;
            out_dash_valid_reg <= held_valid_reg;
            out_last_reg       <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign dash_start_x = out_dash_reg.first.x;
    assign dash_start_y = out_dash_reg.first.y;
    assign dash_end_x   = out_dash_reg.final_pt.x;
    assign dash_end_y   = out_dash_reg.final_pt.y;
    assign dash_valid   = out_dash_valid_reg;
    assign last         = out_last_reg;

endmodule

>>> rtl/dldg_bres_step.sv
module dldg_bres_step (
    input  dldg_pkg::walk_t cur,
    output dldg_pkg::step_t nxt
);

    logic signed [dldg_pkg::ERR_W:0] e2;
    logic signed [dldg_pkg::ERR_W:0] dx_s;
    logic signed [dldg_pkg::ERR_W:0] dy_s;
    logic                            move_x;
    logic                            move_y;
    logic signed [dldg_pkg::ERR_W-1:0] err_x;

    always_comb
    begin
        e2     = {cur.err, 1'b0};
        dx_s   = $signed({{(dldg_pkg::ERR_W + 1 - dldg_pkg::X_W){1'b0}}, cur.dx});
        dy_s   = $signed({{(dldg_pkg::ERR_W + 1 - dldg_pkg::Y_W){1'b0}}, cur.dy});
        move_x = e2 > -dy_s;
        move_y = e2 < dx_s;

        err_x = move_x ? cur.err - dy_s[dldg_pkg::ERR_W-1:0] : cur.err;
        nxt.err = move_y ? err_x + dx_s[dldg_pkg::ERR_W-1:0] : err_x;

        nxt.pos.x = cur.pos.x;
        if (move_x)
        begin
            nxt.pos.x = cur.step_x_up ? cur.pos.x + 1'b1 : cur.pos.x - 1'b1;
        end
        nxt.pos.y = cur.pos.y;
        if (move_y)
        begin
            nxt.pos.y = cur.step_y_up ? cur.pos.y + 1'b1 : cur.pos.y - 1'b1;
        end
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [dldg_pkg::X_W-1:0]   start_x;
        logic [dldg_pkg::Y_W-1:0]   start_y;
        logic [dldg_pkg::X_W-1:0]   end_x;
        logic [dldg_pkg::Y_W-1:0]   end_y;
        logic [dldg_pkg::LEN_W-1:0] phase;
    } line_req_t;

    typedef struct packed {
        logic [dldg_pkg::X_W-1:0] dash_start_x;
        logic [dldg_pkg::Y_W-1:0] dash_start_y;
        logic [dldg_pkg::X_W-1:0] dash_end_x;
        logic [dldg_pkg::Y_W-1:0] dash_end_y;
        logic                     dash_valid;
        logic                     last;
    } dash_rec_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PATTERN
    } rx_mode_t;

    localparam int MAX_DASHES   = 64;
    localparam int IDLE_SETTLE  = 8;
    localparam int HOLD_CYCLES  = 800;
    localparam int HOLD_AT_LINE = 100;
    localparam int RAND_PHASES  = 8;
    localparam int RAND_PER_PHASE = 50;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_en = 1'b0;
    logic                       cfg_addr = 1'b0;
    logic [dldg_pkg::LEN_W-1:0] cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [dldg_pkg::X_W-1:0]   start_x = '0;
    logic [dldg_pkg::Y_W-1:0]   start_y = '0;
    logic [dldg_pkg::X_W-1:0]   end_x = '0;
    logic [dldg_pkg::Y_W-1:0]   end_y = '0;
    logic [dldg_pkg::LEN_W-1:0] phase = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [dldg_pkg::X_W-1:0]   dash_start_x;
    logic [dldg_pkg::Y_W-1:0]   dash_start_y;
    logic [dldg_pkg::X_W-1:0]   dash_end_x;
    logic [dldg_pkg::Y_W-1:0]   dash_end_y;
    logic                       dash_valid;
    logic                       last;

    dash_rec_t dash_expect_q[$];
    line_req_t line_pending_q[$];
    line_req_t cur_line;
    dash_rec_t want_rec;

    logic [dldg_pkg::LEN_W-1:0] dash_len = dldg_pkg::RESET_RUN_LENGTH;
    logic [dldg_pkg::LEN_W-1:0] gap_len  = dldg_pkg::RESET_RUN_LENGTH;

    int error_count = 0;
    int lines_sent = 0;
    int dashes_seen = 0;
    int empty_seen = 0;
    int settings_used = 1;

    int burst_left = 0;
    int gap_left = 0;

    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_mode_left = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    logic [15:0] stall_pattern = 16'b1100_1110_0011_1011;

    dashed_line_dash_generator_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_en       (cfg_en),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .phase        (phase),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .dash_start_x (dash_start_x),
        .dash_start_y (dash_start_y),
        .dash_end_x   (dash_end_x),
        .dash_end_y   (dash_end_y),
        .dash_valid   (dash_valid),
        .last         (last)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("dash %0d %s: got %0d, expected %0d",
                                      dashes_seen, what, got, want));
    endtask

    task automatic queue_dash(input dash_rec_t rec);
        dash_expect_q.insert(dash_expect_q.size(), rec);
    endtask

    task automatic queue_line(input line_req_t l);
        line_pending_q.insert(line_pending_q.size(), l);
    endtask

    // Walk the Bresenham line and queue every closed dash. The newest dash is
    // held back so that the final one can be flagged as last.
    task automatic predict_dashes(input line_req_t req);
        int x, y, ex, ey, dx, dy, stx, sty, err, e2;
        int run_pos, dlen, period, ox, oy, n, guard;
        logic open_dash, have_prev;
        dash_rec_t rec, prev;
        x = int'(req.start_x);
        y = int'(req.start_y);
        ex = int'(req.end_x);
        ey = int'(req.end_y);
        dx = (ex > x) ? ex - x : x - ex;
        dy = (ey > y) ? ey - y : y - ey;
        stx = (x < ex) ? 1 : -1;
        sty = (y < ey) ? 1 : -1;
        err = dx - dy;
        dlen = int'(dash_len);
        period = dlen + int'(gap_len);
        run_pos = -int'(req.phase);
        ox = 0;
        oy = 0;
        n = 0;
        guard = 0;
        open_dash = 1'b0;
        have_prev = 1'b0;
        prev = '0;
        while ((x != ex || y != ey) && guard < 4096) begin
            guard++;
            if (run_pos >= 0 && run_pos < dlen && !open_dash) begin
                ox = x;
                oy = y;
                open_dash = 1'b1;
            end
            run_pos++;
            if (run_pos >= period) begin
                run_pos = 0;
            end
            else if (run_pos >= dlen && open_dash) begin
                open_dash = 1'b0;
                if (n < MAX_DASHES) begin
                    rec.dash_start_x = ox[dldg_pkg::X_W-1:0];
                    rec.dash_start_y = oy[dldg_pkg::Y_W-1:0];
                    rec.dash_end_x   = x[dldg_pkg::X_W-1:0];
                    rec.dash_end_y   = y[dldg_pkg::Y_W-1:0];
                    rec.dash_valid   = 1'b1;
                    rec.last         = 1'b0;
                    if (have_prev)
                        queue_dash(prev);
                    prev = rec;
                    have_prev = 1'b1;
                    n++;
                end
            end
            e2 = 2 * err;
            if (e2 > -dy) begin
                err -= dy;
                x += stx;
            end
            if (e2 < dx) begin
                err += dx;
                y += sty;
            end
        end
        if (!have_prev) begin
            prev = '0;
            prev.last = 1'b1;
        end
        else begin
            prev.last = 1'b1;
        end
        queue_dash(prev);
    endtask

    function automatic line_req_t random_line();
        line_req_t l;
        int kind, tx, ty;
        kind = $urandom_range(0, 19);
        l.start_x = $urandom_range(0, 639);
        l.start_y = $urandom_range(0, 399);
        l.end_x   = $urandom_range(0, 639);
        l.end_y   = $urandom_range(0, 399);
        l.phase   = $urandom_range(0, 14);
        if (kind == 0) begin
            // full field width, beyond the screen
            l.start_x = $urandom_range(0, 1023);
            l.start_y = $urandom_range(0, 511);
            l.end_x   = $urandom_range(0, 1023);
            l.end_y   = $urandom_range(0, 511);
            l.phase   = $urandom_range(0, 15);
        end
        else if (kind == 1) begin
            l.end_x = l.start_x;
            l.end_y = l.start_y;
        end
        else if (kind < 7) begin
            tx = int'(l.start_x) + int'($urandom_range(0, 24)) - 12;
            ty = int'(l.start_y) + int'($urandom_range(0, 24)) - 12;
            tx = (tx < 0) ? 0 : ((tx > 639) ? 639 : tx);
            ty = (ty < 0) ? 0 : ((ty > 399) ? 399 : ty);
            l.end_x = tx[dldg_pkg::X_W-1:0];
            l.end_y = ty[dldg_pkg::Y_W-1:0];
        end
        return l;
    endfunction

    task automatic add_line(input int sx, input int sy, input int ex, input int ey,
                            input int ph);
        line_req_t l;
        l.start_x = sx[dldg_pkg::X_W-1:0];
        l.start_y = sy[dldg_pkg::Y_W-1:0];
        l.end_x   = ex[dldg_pkg::X_W-1:0];
        l.end_y   = ey[dldg_pkg::Y_W-1:0];
        l.phase   = ph[dldg_pkg::LEN_W-1:0];
        queue_line(l);
    endtask

    // Sample at the falling edge so the check never races the clocked blocks.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (line_pending_q.size() != 0 || in_valid || dash_expect_q.size() != 0);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic addr, input logic [dldg_pkg::LEN_W-1:0] val);
        @(posedge clk);
        cfg_en   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= val;
        if (addr == dldg_pkg::REG_DASH_LENGTH)
            dash_len = val;
        else
            gap_len = val;
        @(posedge clk);
        cfg_en <= 1'b0;
    endtask

    task automatic set_lengths(input int dl, input int gl);
        wait_idle();
        write_reg(dldg_pkg::REG_DASH_LENGTH, dl[dldg_pkg::LEN_W-1:0]);
        write_reg(dldg_pkg::REG_GAP_LENGTH, gl[dldg_pkg::LEN_W-1:0]);
        settings_used++;
        @(negedge clk);
    endtask

    // Sender: bursts of transfers separated by random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (in_valid && in_ready) begin
                predict_dashes(cur_line);
                lines_sent++;
            end
            if (!in_valid || in_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (line_pending_q.size() != 0) begin
                    cur_line = line_pending_q.pop_front();
                    start_x  <= cur_line.start_x;
                    start_y  <= cur_line.start_y;
                    end_x    <= cur_line.end_x;
                    end_y    <= cur_line.end_y;
                    phase    <= cur_line.phase;
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 6);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else begin
                        burst_left <= burst_left - 1;
                    end
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern that changes mode now and then, plus one long hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!hold_done && lines_sent >= HOLD_AT_LINE) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= rx_mode_t'($urandom_range(0, 3));
                rx_mode_left <= $urandom_range(16, 160);
            end
            else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
            case (rx_mode)
                RX_OPEN:   out_ready <= 1'b1;
                RX_COIN:   out_ready <= $urandom_range(0, 1);
                RX_SPARSE: out_ready <= ($urandom_range(0, 2) == 0);
                default:   out_ready <= stall_pattern[0];
            endcase
        end
    end

    // Check each result transfer against the oldest expected dash
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (dash_expect_q.size() == 0) begin
                report_mismatch("result transfer with no dash expected");
            end
            else begin
                want_rec = dash_expect_q.pop_front();
                check_field("dash_start_x", dash_start_x, want_rec.dash_start_x);
                check_field("dash_start_y", dash_start_y, want_rec.dash_start_y);
                check_field("dash_end_x", dash_end_x, want_rec.dash_end_x);
                check_field("dash_end_y", dash_end_y, want_rec.dash_end_y);
                check_field("dash_valid", dash_valid, want_rec.dash_valid);
                check_field("last", last, want_rec.last);
                if (!want_rec.dash_valid)
                    empty_seen++;
            end
            dashes_seen++;
        end
    end

    initial begin : stimulus
        int k, dl, gl, i;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset lengths: empty lines, dropped open dash, full and oversized lines
        add_line(100, 100, 100, 100, 0);
        add_line(0, 0, 3, 0, 0);
        add_line(0, 0, 639, 0, 0);
        add_line(0, 0, 0, 399, 14);
        add_line(639, 399, 0, 0, 7);
        add_line(10, 399, 600, 0, 3);
        add_line(639, 0, 0, 399, 8);
        add_line(512, 256, 520, 300, 1);
        add_line(0, 0, 1023, 0, 0);
        add_line(1023, 511, 0, 0, 15);
        add_line(300, 200, 306, 200, 0);

        set_lengths(15, 15);
        add_line(0, 399, 639, 0, 14);
        add_line(5, 5, 40, 9, 0);

        // zero dash length never opens a dash
        set_lengths(0, 5);
        add_line(0, 0, 100, 50, 0);

        // zero gap length wraps before the dash can close
        set_lengths(7, 0);
        add_line(0, 0, 200, 0, 2);

        set_lengths(5, 15);
        add_line(20, 30, 600, 390, 5);

        set_lengths(15, 5);
        add_line(600, 10, 20, 380, 0);

        for (k = 0; k < RAND_PHASES; k++) begin
            case (k)
                0: begin dl = 5;  gl = 5;  end
                1: begin dl = 15; gl = 15; end
                2: begin dl = 5;  gl = 15; end
                3: begin dl = 15; gl = 5;  end
                5: begin dl = $urandom_range(0, 4); gl = $urandom_range(0, 15); end
                default: begin dl = $urandom_range(5, 15); gl = $urandom_range(5, 15); end
            endcase
            set_lengths(dl, gl);
            for (i = 0; i < RAND_PER_PHASE; i++)
                queue_line(random_line());
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (dash_expect_q.size() != 0)
            report_mismatch($sformatf("%0d dashes never arrived", dash_expect_q.size()));

        $display("Ran %0d line requests through %0d length settings;", lines_sent,
                 settings_used);
        $display("checked %0d result transfers, %0d of them empty-line results.",
                 dashes_seen, empty_seen);
        if (error_count == 0)
            $display("** dashed_line_dash_generator_unit: PASSED **");
        else
            $display("** dashed_line_dash_generator_unit: FAILED **");
        $finish;
    end

    initial begin : watchdog
        #32_000_000;
        $display("Timeout with %0d dashes still expected", dash_expect_q.size());
        $display("** dashed_line_dash_generator_unit: FAILED **");
        $finish;
    end

endmodule
